>>> rtl/md5_digest_engine_unit_assert.svh
// Assertion macros shared by the md5 digest engine RTL
`ifndef MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH
`define MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define MD5DE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define MD5DE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/md5de_pkg.sv
// Types, constants and round tables of the md5 digest engine
package md5de_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 3;
    localparam int TOTAL_W = 61;

    localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

    localparam logic [CNT_W-1:0] FULL_COUNT = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LEN   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_FOLD  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // Where to continue once a compression has been folded in
    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_LEN  = 2'd2,
        RET_EMIT = 2'd3
    } t_ret;

    typedef struct packed {
        logic       latch_in;
        logic       store_word;
        logic       pad;
        logic       pad_len;
        logic       len_only;
        logic       load_work;
        logic       round_en;
        logic       fold;
        logic       msg_reset;
        logic       emit_load;
        logic [5:0] round;
        logic [1:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic fill_last;
        logic pad_late;
        logic out_free;
        logic last_in;
    } t_status;

    function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    // Rotate amount by {phase, round[1:0]}
    function automatic logic [4:0] rot_amt(input logic [3:0] sel);
        logic [4:0] s;
        case (sel)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/md5de_stream_if.sv
// Valid/ready stream interfaces for message words and digest words
interface md5de_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface md5de_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_done;

    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

>>> rtl/md5_digest_engine_unit.sv
// Top level of the MD5 digest engine: stream interfaces, sequencer and datapath
// Feeds a message as little-endian 32-bit words (first byte in bits 7:0) and returns its
// MD5 digest as four words A, B, C, D with word_index 0..3, digest_done set on D. Only the
// word marked last_word may carry fewer than four bytes (byte_count 0..3; 5..7 count as 4);
// other words always count four bytes. Words are accepted back to back while the sequencer
// is idle. Every sixteenth word starts a compression on the single round unit: a load step,
// 64 rounds and a fold step. The last word adds a padding step, one compression, or two with
// a length-only step between them when the tail leaves no room for the length, and then four
// output transactions. Input is not taken while a compression runs; the next message may
// start while the final digest word waits.
`include "md5_digest_engine_unit_assert.svh"

module md5_digest_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5de_in_if.sink    i_din,
    md5de_out_if.source o_dout
);

    md5de_pkg::t_cmd    cmd;
    md5de_pkg::t_status status;

    md5de_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_din.valid),
        .o_in_ready (i_din.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    md5de_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data_word   (i_din.data_word),
        .i_byte_count  (i_din.byte_count),
        .i_last_word   (i_din.last_word),
        .o_out_valid   (o_dout.valid),
        .i_out_ready   (o_dout.ready),
        .o_digest_word (o_dout.digest_word),
        .o_word_index  (o_dout.word_index),
        .o_digest_done (o_dout.digest_done)
    );

    `MD5DE_ASSERT_IMP(a_busy_in_rounds, cmd.round_en, !i_din.ready, "input taken during rounds")
    `MD5DE_ASSERT_IMP(a_done_on_last, o_dout.valid && o_dout.digest_done, o_dout.word_index == 2'd3, "digest_done off word D")
    `MD5DE_ASSERT_NXT(a_reset_after_d, cmd.msg_reset, o_dout.valid && o_dout.digest_done, "restart without word D")

endmodule

>>> rtl/md5de_ctrl.sv
// Sequencer: message intake, padding steps, 64-round compression and digest emission
module md5de_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  md5de_pkg::t_status i_status,
    output md5de_pkg::t_cmd    o_cmd
);

    md5de_pkg::t_state r_state, n_state;
    md5de_pkg::t_ret   r_ret, n_ret;
    logic [5:0]        r_round, n_round;
    logic [1:0]        r_eidx, n_eidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5de_pkg::S_IDLE;
            r_ret   <= md5de_pkg::RET_IDLE;
            r_round <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_eidx  <= n_eidx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_round    = r_round;
        n_eidx     = r_eidx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            md5de_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    if (i_status.in_full) begin
                        o_cmd.store_word = 1'b1;
                        if (i_status.fill_last) begin
                            // block is full: compress, then pad if this ended the message
                            n_ret   = i_status.last_in ? md5de_pkg::RET_PAD
                                                       : md5de_pkg::RET_IDLE;
                            n_state = md5de_pkg::S_LOAD;
                        end else if (i_status.last_in) begin
                            n_state = md5de_pkg::S_PAD;
                        end
                    end else begin
                        n_state = md5de_pkg::S_PAD;
                    end
                end
            end
            md5de_pkg::S_PAD: begin
                o_cmd.pad     = 1'b1;
                o_cmd.pad_len = !i_status.pad_late;
                n_ret         = i_status.pad_late ? md5de_pkg::RET_LEN : md5de_pkg::RET_EMIT;
                n_state       = md5de_pkg::S_LOAD;
            end
            md5de_pkg::S_LEN: begin
                o_cmd.len_only = 1'b1;
                n_ret          = md5de_pkg::RET_EMIT;
                n_state        = md5de_pkg::S_LOAD;
            end
            md5de_pkg::S_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round         = '0;
                n_state         = md5de_pkg::S_ROUND;
            end
            md5de_pkg::S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round        = r_round + 6'd1;
                if (&r_round) begin
                    n_state = md5de_pkg::S_FOLD;
                end
            end
            md5de_pkg::S_FOLD: begin
                o_cmd.fold = 1'b1;
                unique case (r_ret)
                    md5de_pkg::RET_IDLE: n_state = md5de_pkg::S_IDLE;
                    md5de_pkg::RET_PAD:  n_state = md5de_pkg::S_PAD;
                    md5de_pkg::RET_LEN:  n_state = md5de_pkg::S_LEN;
                    default: begin
                        n_state = md5de_pkg::S_EMIT;
                        n_eidx  = '0;
                    end
                endcase
            end
            md5de_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_eidx          = r_eidx + 2'd1;
                    if (&r_eidx) begin
                        // last word copied out: restart for the next message
                        o_cmd.msg_reset = 1'b1;
                        n_state         = md5de_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = md5de_pkg::S_IDLE;
        endcase
        o_cmd.round    = r_round;
        o_cmd.emit_idx = r_eidx;
    end

endmodule

>>> rtl/md5de_dp.sv
// Datapath: block store, length counter, round unit, chaining words and digest output register
module md5de_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  md5de_pkg::t_cmd    i_cmd,
    output md5de_pkg::t_status o_status,
    input  logic [31:0]        i_data_word,
    input  logic [2:0]         i_byte_count,
    input  logic               i_last_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_digest_word,
    output logic [1:0]         o_word_index,
    output logic               o_digest_done
);

    logic [md5de_pkg::WORD_W-1:0]  r_chain [4];
    logic [md5de_pkg::WORD_W-1:0]  r_work  [4];
    logic [md5de_pkg::WORD_W-1:0]  r_blk   [16];
    logic [3:0]                    r_fill;
    logic [md5de_pkg::TOTAL_W-1:0] r_total;
    logic [md5de_pkg::WORD_W-1:0]  r_data;
    logic [md5de_pkg::CNT_W-1:0]   r_cnt;
    logic                          r_ovld;
    logic [md5de_pkg::WORD_W-1:0]  r_oword;
    logic [1:0]                    r_oidx;
    logic                          r_odone;

    logic [md5de_pkg::CNT_W-1:0]   eff_cnt;
    logic [1:0]                    pad_cnt;
    logic [md5de_pkg::WORD_W-1:0]  pad_mask;
    logic [md5de_pkg::WORD_W-1:0]  pad_mark;
    logic [md5de_pkg::WORD_W-1:0]  pad_word;
    logic [63:0]                   len_bits;
    logic [1:0]                    phase;
    logic [3:0]                    rnd4;
    logic [3:0]                    g_idx;
    logic [md5de_pkg::WORD_W-1:0]  f_val;
    logic [md5de_pkg::WORD_W-1:0]  sum;
    logic [63:0]                   rot_dbl;
    logic [md5de_pkg::WORD_W-1:0]  new_b;

    // A short count only counts on the last word; 5..7 saturate to a full word
    always_comb begin
        if (!i_last_word || i_byte_count > md5de_pkg::FULL_COUNT) begin
            eff_cnt = md5de_pkg::FULL_COUNT;
        end else begin
            eff_cnt = i_byte_count;
        end
    end

    // Marker position: a full last word puts the marker in a fresh word
    assign pad_cnt = (r_cnt == md5de_pkg::FULL_COUNT) ? 2'd0 : r_cnt[1:0];

    always_comb begin
        case (pad_cnt)
            2'd0:    begin pad_mask = 32'h00000000; pad_mark = 32'h00000080; end
            2'd1:    begin pad_mask = 32'h000000ff; pad_mark = 32'h00008000; end
            2'd2:    begin pad_mask = 32'h0000ffff; pad_mark = 32'h00800000; end
            default: begin pad_mask = 32'h00ffffff; pad_mark = 32'h80000000; end
        endcase
    end

    assign pad_word = (r_data & pad_mask) | pad_mark;
    assign len_bits = {r_total, 3'b000};

    // Round function and message word select
    assign phase = i_cmd.round[5:4];
    assign rnd4  = i_cmd.round[3:0];

    always_comb begin
        case (phase)
            2'd0: begin
                f_val = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
                g_idx = rnd4;
            end
            2'd1: begin
                f_val = (r_work[3] & r_work[1]) | (~r_work[3] & r_work[2]);
                g_idx = rnd4 * 4'd5 + 4'd1;
            end
            2'd2: begin
                f_val = r_work[1] ^ r_work[2] ^ r_work[3];
                g_idx = rnd4 * 4'd3 + 4'd5;
            end
            default: begin
                f_val = r_work[2] ^ (r_work[1] | ~r_work[3]);
                g_idx = rnd4 * 4'd7;
            end
        endcase
    end

    assign sum     = r_work[0] + f_val + md5de_pkg::round_k(i_cmd.round) + r_blk[g_idx];
    assign rot_dbl = {sum, sum} << md5de_pkg::rot_amt({phase, rnd4[1:0]});
    assign new_b   = r_work[1] + rot_dbl[63:32];

    // Control-side registers: chaining words, fill, length, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= md5de_pkg::INIT_A;
            r_chain[1] <= md5de_pkg::INIT_B;
            r_chain[2] <= md5de_pkg::INIT_C;
            r_chain[3] <= md5de_pkg::INIT_D;
            r_fill     <= '0;
            r_total    <= '0;
            r_ovld     <= 1'b0;
        end else begin
            if (i_cmd.latch_in) begin
                r_total <= r_total + md5de_pkg::TOTAL_W'(eff_cnt);
            end
            if (i_cmd.store_word) begin
                r_fill <= r_fill + 4'd1;
            end
            if (i_cmd.fold) begin
                for (int k = 0; k < 4; k++) begin
                    r_chain[k] <= r_chain[k] + r_work[k];
                end
            end
            if (i_cmd.msg_reset) begin
                r_chain[0] <= md5de_pkg::INIT_A;
                r_chain[1] <= md5de_pkg::INIT_B;
                r_chain[2] <= md5de_pkg::INIT_C;
                r_chain[3] <= md5de_pkg::INIT_D;
                r_fill     <= '0;
                r_total    <= '0;
            end
            if (i_cmd.emit_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_data <= i_data_word;
            r_cnt  <= eff_cnt;
        end
        if (i_cmd.store_word) begin
            r_blk[r_fill] <= i_data_word;
        end
        if (i_cmd.pad) begin
            for (int j = 0; j < 16; j++) begin
                if (i_cmd.pad_len && j == 14) begin
                    r_blk[j] <= len_bits[31:0];
                end else if (i_cmd.pad_len && j == 15) begin
                    r_blk[j] <= len_bits[63:32];
                end else if (4'(j) == r_fill) begin
                    r_blk[j] <= pad_word;
                end else if (4'(j) > r_fill) begin
                    r_blk[j] <= '0;
                end
            end
        end
        if (i_cmd.len_only) begin
            for (int j = 0; j < 14; j++) begin
                r_blk[j] <= '0;
            end
            r_blk[14] <= len_bits[31:0];
            r_blk[15] <= len_bits[63:32];
        end
        if (i_cmd.load_work) begin
            for (int k = 0; k < 4; k++) begin
                r_work[k] <= r_chain[k];
            end
        end
        if (i_cmd.round_en) begin
            r_work[0] <= r_work[3];
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= new_b;
        end
        if (i_cmd.emit_load) begin
            r_oword <= r_chain[i_cmd.emit_idx];
            r_oidx  <= i_cmd.emit_idx;
            r_odone <= &i_cmd.emit_idx;
        end
    end

    assign o_status.in_full   = (eff_cnt == md5de_pkg::FULL_COUNT);
    assign o_status.fill_last = &r_fill;
    assign o_status.pad_late  = (r_fill >= 4'd14);
    assign o_status.out_free  = !r_ovld || i_out_ready;
    assign o_status.last_in   = i_last_word;

    assign o_out_valid   = r_ovld;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_digest_done = r_odone;

endmodule
